[hdl/sc2a_pkg.sv]
// Package: scan code constants, special key codes and the set-1 key table.
`default_nettype none

package sc2a_pkg;

    // Bytes swallowed after a pause sequence start
    localparam int PAUSE_SKIP_COUNT = 2;
    // Press codes below this limit count as inside the key table
    localparam int TABLE_ENTRIES    = 89;

    localparam logic [2:0] SKIP_LOAD   = 3'(PAUSE_SKIP_COUNT);
    localparam logic [7:0] TABLE_LIMIT = 8'(TABLE_ENTRIES);

    // Prefix bytes
    localparam logic [7:0] BYTE_PAUSE    = 8'hE1;
    localparam logic [7:0] BYTE_EXTENDED = 8'hE0;

    // Press codes that only update modifier state
    localparam logic [6:0] CODE_LSHIFT   = 7'd42;
    localparam logic [6:0] CODE_RSHIFT   = 7'd54;
    localparam logic [6:0] CODE_CAPS     = 7'd58;
    localparam logic [6:0] CODE_NUMLOCK  = 7'd69;

    // Ranges for the combined-code choice
    localparam logic [6:0] SYMBOL_FIRST  = 7'd2;
    localparam logic [6:0] SYMBOL_LAST   = 7'd53;
    localparam logic [6:0] NUMPAD_FIRST  = 7'd71;
    localparam logic [6:0] NUMPAD_LAST   = 7'd83;

    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;

    // Key code reported for the pause key
    localparam logic [7:0] KEY_PAUSE     = 8'hA0;

    typedef struct packed {
        logic [7:0] normal;
        logic [7:0] combined;
    } key_entry_t;

    // Set-1 key table, indexed by press code
    function automatic key_entry_t key_lookup(input logic [6:0] code);
        key_entry_t e;
        e = '{normal: 8'h00, combined: 8'h00};
        case (code)
            7'd1:  e = '{8'h1B, 8'h1B};
            7'd2:  e = '{8'h31, 8'h21};
            7'd3:  e = '{8'h32, 8'h40};
            7'd4:  e = '{8'h33, 8'h23};
            7'd5:  e = '{8'h34, 8'h24};
            7'd6:  e = '{8'h35, 8'h25};
            7'd7:  e = '{8'h36, 8'h5E};
            7'd8:  e = '{8'h37, 8'h26};
            7'd9:  e = '{8'h38, 8'h2A};
            7'd10: e = '{8'h39, 8'h28};
            7'd11: e = '{8'h30, 8'h29};
            7'd12: e = '{8'h2D, 8'h5F};
            7'd13: e = '{8'h3D, 8'h2B};
            7'd14: e = '{8'h08, 8'h08};
            7'd15: e = '{8'h09, 8'h09};
            7'd16: e = '{8'h71, 8'h51};
            7'd17: e = '{8'h77, 8'h57};
            7'd18: e = '{8'h65, 8'h45};
            7'd19: e = '{8'h72, 8'h52};
            7'd20: e = '{8'h74, 8'h54};
            7'd21: e = '{8'h79, 8'h59};
            7'd22: e = '{8'h75, 8'h55};
            7'd23: e = '{8'h69, 8'h49};
            7'd24: e = '{8'h6F, 8'h4F};
            7'd25: e = '{8'h70, 8'h50};
            7'd26: e = '{8'h5B, 8'h7B};
            7'd27: e = '{8'h5D, 8'h7D};
            7'd28: e = '{8'h0A, 8'h0A};
            7'd29: e = '{8'h81, 8'h81};
            7'd30: e = '{8'h61, 8'h41};
            7'd31: e = '{8'h73, 8'h53};
            7'd32: e = '{8'h64, 8'h44};
            7'd33: e = '{8'h66, 8'h46};
            7'd34: e = '{8'h67, 8'h47};
            7'd35: e = '{8'h68, 8'h48};
            7'd36: e = '{8'h6A, 8'h4A};
            7'd37: e = '{8'h6B, 8'h4B};
            7'd38: e = '{8'h6C, 8'h4C};
            7'd39: e = '{8'h3B, 8'h3A};
            7'd40: e = '{8'h27, 8'h22};
            7'd41: e = '{8'h60, 8'h7E};
            7'd42: e = '{8'h82, 8'h82};
            7'd43: e = '{8'h5C, 8'h7C};
            7'd44: e = '{8'h7A, 8'h5A};
            7'd45: e = '{8'h78, 8'h58};
            7'd46: e = '{8'h63, 8'h43};
            7'd47: e = '{8'h76, 8'h56};
            7'd48: e = '{8'h62, 8'h42};
            7'd49: e = '{8'h6E, 8'h4E};
            7'd50: e = '{8'h6D, 8'h4D};
            7'd51: e = '{8'h2C, 8'h3C};
            7'd52: e = '{8'h2E, 8'h3E};
            7'd53: e = '{8'h2F, 8'h3F};
            7'd54: e = '{8'h83, 8'h83};
            7'd55: e = '{8'h2A, 8'h2A};
            7'd56: e = '{8'h85, 8'h85};
            7'd57: e = '{8'h20, 8'h20};
            7'd58: e = '{8'h86, 8'h86};
            7'd59: e = '{8'h87, 8'h87};
            7'd60: e = '{8'h88, 8'h88};
            7'd61: e = '{8'h89, 8'h89};
            7'd62: e = '{8'h8A, 8'h8A};
            7'd63: e = '{8'h8B, 8'h8B};
            7'd64: e = '{8'h8C, 8'h8C};
            7'd65: e = '{8'h8D, 8'h8D};
            7'd66: e = '{8'h8E, 8'h8E};
            7'd67: e = '{8'h8F, 8'h8F};
            7'd68: e = '{8'h90, 8'h90};
            7'd69: e = '{8'h91, 8'h91};
            7'd70: e = '{8'h92, 8'h92};
            7'd71: e = '{8'h93, 8'h37};
            7'd72: e = '{8'h94, 8'h38};
            7'd73: e = '{8'h95, 8'h39};
            7'd74: e = '{8'h2D, 8'h2D};
            7'd75: e = '{8'h96, 8'h34};
            7'd76: e = '{8'h97, 8'h35};
            7'd77: e = '{8'h98, 8'h36};
            7'd78: e = '{8'h2B, 8'h2B};
            7'd79: e = '{8'h99, 8'h31};
            7'd80: e = '{8'h9A, 8'h32};
            7'd81: e = '{8'h9B, 8'h33};
            7'd82: e = '{8'h9C, 8'h30};
            7'd83: e = '{8'h9D, 8'h2E};
            7'd87: e = '{8'h9E, 8'h9E};
            7'd88: e = '{8'h9F, 8'h9F};
            default: e = '{normal: 8'h00, combined: 8'h00};
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

[hdl/scan_code_to_ascii_converter_top.sv]
// Top level: PS/2 set-1 scan byte to key code converter with modifier tracking.
`default_nettype none

// Takes one scan byte per request on the scan channel and returns at most one
// key event per byte on the key channel. A byte is registered at the input,
// decoded against the shift, caps lock, num lock, extended prefix and pause
// skip state, and the event lands in the result register. Throughput is one
// byte per cycle while key_ready stays high; key_valid rises when the result
// register takes an event from the input register. While a result waits
// on a low key_ready, the byte in the input register waits too, whether or not
// it yields an event, and scan_ready drops once that register is full. Bytes
// that only change state (E0, E1 follow-up bytes, shift, caps and num lock
// presses) produce no key event.
module scan_code_to_ascii_converter_top
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       scan_valid,
    output logic            scan_ready,
    input  wire logic [7:0] scan_byte,
    output logic            key_valid,
    input  wire logic       key_ready,
    output logic [7:0]      key_code,
    output logic            key_pressed,
    output logic            extended_key
);
    import sc2a_pkg::*;

    // Input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Key state
    logic       shift_reg,  shift_next;
    logic       caps_reg,   caps_next;
    logic       num_reg,    num_next;
    logic       prefix_reg, prefix_next;
    logic [2:0] skip_reg,   skip_next;

    // Result stage
    logic       out_valid_reg;
    logic [7:0] code_reg,    code_next;
    logic       pressed_reg;
    logic       ext_reg,     ext_next;

    logic       advance;
    logic       out_free;
    logic       emit;
    logic       lookup;
    logic [6:0] code;
    logic       pressed;
    logic       in_table;
    logic       is_letter;
    logic       use_combined;
    key_entry_t entry;

    assign code     = in_byte_reg[6:0];
    assign pressed  = ~in_byte_reg[7];
    assign out_free = ~out_valid_reg | key_ready;
    assign advance  = in_valid_reg & out_free;

    assign scan_ready = ~in_valid_reg | advance;

    // Table lookup and combined-code choice
    assign entry     = key_lookup(code);
    assign in_table  = ({1'b0, code} < TABLE_LIMIT);
    assign is_letter = in_table & (entry.normal >= ASCII_LOWER_A)
                     & (entry.normal <= ASCII_LOWER_Z);

    always_comb
    begin
        priority if (is_letter)
        begin
            use_combined = shift_reg ^ caps_reg;
        end
        else if (code >= SYMBOL_FIRST && code <= SYMBOL_LAST)
        begin
            use_combined = shift_reg;
        end
        else if (code >= NUMPAD_FIRST && code <= NUMPAD_LAST && !prefix_reg)
        begin
            use_combined = num_reg;
        end
        else
        begin
            use_combined = 1'b0;
        end
    end

    // Decode one byte: update state, decide whether it yields an event
    always_comb
    begin
        shift_next  = shift_reg;
        caps_next   = caps_reg;
        num_next    = num_reg;
        prefix_next = prefix_reg;
        skip_next   = skip_reg;
        emit        = 1'b0;
        lookup      = 1'b0;
        code_next   = KEY_PAUSE;
        ext_next    = 1'b0;
        priority if (skip_reg != 3'd0)
        begin
            skip_next = skip_reg - 3'd1;
        end
        else if (in_byte_reg == BYTE_PAUSE)
        begin
            skip_next = SKIP_LOAD;
            emit      = 1'b1;
        end
        else if (in_byte_reg == BYTE_EXTENDED)
        begin
            prefix_next = 1'b1;
        end
        else if (code == CODE_LSHIFT || code == CODE_RSHIFT)
        begin
            shift_next = pressed;
        end
        else if (code == CODE_CAPS && pressed)
        begin
            caps_next = ~caps_reg;
        end
        else if (code == CODE_NUMLOCK && pressed)
        begin
            num_next = ~num_reg;
        end
        else
        begin
            emit        = 1'b1;
            lookup      = 1'b1;
            prefix_next = 1'b0;
            ext_next    = prefix_reg;
            if (!in_table)
            begin
                code_next = 8'h00;
            end
            else if (use_combined)
            begin
                code_next = entry.combined;
            end
            else
            begin
                code_next = entry.normal;
            end
        end
    end

    // Hold the incoming byte until the decode stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (scan_ready)
        begin
            in_valid_reg <= scan_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_valid && scan_ready)
        begin
            in_byte_reg <= scan_byte;
        end
    end

    // Advance key state once per decoded byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= 1'b0;
            caps_reg   <= 1'b0;
            num_reg    <= 1'b0;
            prefix_reg <= 1'b0;
            skip_reg   <= 3'd0;
        end
        else if (advance)
        begin
            shift_reg  <= shift_next;
            caps_reg   <= caps_next;
            num_reg    <= num_next;
            prefix_reg <= prefix_next;
            skip_reg   <= skip_next;
        end
    end

    // Result register: load on an event, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance & emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            code_reg    <= code_next;
            pressed_reg <= pressed | ~lookup;
            ext_reg     <= ext_next;
        end
    end

    assign key_valid    = out_valid_reg;
    assign key_code     = code_reg;
    assign key_pressed  = pressed_reg;
    assign extended_key = ext_reg;

`ifndef SYNTHESIS
    // Skip counter never exceeds its load value
    a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg <= SKIP_LOAD)
        else $error("pause skip counter out of range");

    // A pause byte outside a skip window loads the skip counter
    a_pause_load: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && skip_reg == 3'd0 && in_byte_reg == BYTE_PAUSE)
        |=> (skip_reg == SKIP_LOAD && out_valid_reg && code_reg == KEY_PAUSE))
        else $error("pause byte did not load skip counter and event");

    // A skipped byte counts down and produces no event
    a_skip_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && skip_reg != 3'd0)
        |=> (skip_reg == $past(skip_reg) - 3'd1 && !out_valid_reg))
        else $error("skipped byte mishandled");

    // A looked-up key clears the extended prefix
    a_prefix_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && lookup) |=> !prefix_reg)
        else $error("extended prefix not cleared after key");
`endif

endmodule

`default_nettype wire
